[rtl/core/kwc_pkg.sv]
// shared constants, types and byte classification helpers for the keyword
// token match counter; no dependencies
`default_nettype none

package kwc_pkg;

    localparam int KWC_NUM_KEYWORDS = 8;
    localparam int KWC_KEY_CHARS    = 8;
    localparam int KWC_COUNT_WIDTH  = 32;

    localparam int KWC_BYTE_W    = 8;
    localparam int KWC_SLOT_W    = 64;
    localparam int KWC_IDX_W     = 3;
    localparam int KWC_MATCH_W   = 32;
    localparam int KWC_REG_IDX_W = 3;

    localparam logic [KWC_BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [KWC_BYTE_W-1:0] CH_CR      = 8'h0d;
    localparam logic [KWC_BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [KWC_BYTE_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [KWC_BYTE_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [KWC_BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [KWC_BYTE_W-1:0] CH_UPPER_Z = 8'h5a;
    localparam logic [KWC_BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [KWC_BYTE_W-1:0] CH_LOWER_Z = 8'h7a;
    localparam logic [KWC_BYTE_W-1:0] CASE_DELTA = 8'h20;

    // status that travels with a token down the cell row
    typedef struct packed {
        logic                 too_long;
        logic                 matched;
        logic [KWC_IDX_W-1:0] index;
    } t_tag;

    function automatic logic is_space(input logic [KWC_BYTE_W-1:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_upper(input logic [KWC_BYTE_W-1:0] b);
        return (b >= CH_UPPER_A) && (b <= CH_UPPER_Z);
    endfunction

    function automatic logic is_kept(input logic [KWC_BYTE_W-1:0] b);
        return ((b >= CH_DIGIT_0) && (b <= CH_DIGIT_9)) ||
               ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) || is_upper(b);
    endfunction

    function automatic logic [KWC_BYTE_W-1:0] fold_case(input logic [KWC_BYTE_W-1:0] b);
        return is_upper(b) ? (b + CASE_DELTA) : b;
    endfunction

endpackage

`default_nettype wire

[rtl/core/kwc_in_if.sv]
// input channel: one text byte per beat with its end of chunk flag
// depends on kwc_pkg
`default_nettype none

interface kwc_in_if;
    logic                            valid;
    logic                            ready;
    logic [kwc_pkg::KWC_BYTE_W-1:0]  text_byte;
    logic                            end_of_chunk;

    modport source(output valid, output text_byte, output end_of_chunk, input ready);
    modport sink(input valid, input text_byte, input end_of_chunk, output ready);
endinterface

`default_nettype wire

[rtl/core/kwc_out_if.sv]
// output channel: one match result per beat
// depends on kwc_pkg
`default_nettype none

interface kwc_out_if;
    logic                             valid;
    logic                             ready;
    logic                             matched;
    logic [kwc_pkg::KWC_IDX_W-1:0]    keyword_index;
    logic [kwc_pkg::KWC_MATCH_W-1:0]  match_count;

    modport source(output valid, output matched, output keyword_index,
                   output match_count, input ready);
    modport sink(input valid, input matched, input keyword_index,
                 input match_count, output ready);
endinterface

`default_nettype wire

[rtl/core/kwc_tokenizer.sv]
// splits the byte stream into normalized tokens and registers each finished
// token for the cell row; depends on kwc_pkg
`default_nettype none

module kwc_tokenizer #(
    parameter int KEY_CHARS = kwc_pkg::KWC_KEY_CHARS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output      logic                           o_ready,
    input  wire logic [kwc_pkg::KWC_BYTE_W-1:0] i_text_byte,
    input  wire logic                           i_end_of_chunk,
    output      logic                           o_valid,
    input  wire logic                           i_ready,
    output      logic [8*KEY_CHARS-1:0]         o_token,
    output      kwc_pkg::t_tag                  o_tag
);

    localparam int LEN_W = $clog2(KEY_CHARS + 1);

    logic [kwc_pkg::KWC_BYTE_W-1:0] r_chars [KEY_CHARS];
    logic [kwc_pkg::KWC_BYTE_W-1:0] n_chars [KEY_CHARS];
    logic [LEN_W-1:0]               r_len, n_len;
    logic                           r_long, n_long;
    logic                           r_valid;
    logic [8*KEY_CHARS-1:0]         r_token, n_token;
    kwc_pkg::t_tag                  r_tag;

    logic                           accept;
    logic                           space, kept, add_ok, finish, emit;
    logic [kwc_pkg::KWC_BYTE_W-1:0] folded;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        space  = kwc_pkg::is_space(i_text_byte);
        kept   = kwc_pkg::is_kept(i_text_byte);
        folded = kwc_pkg::fold_case(i_text_byte);
        add_ok = kept && !r_long && (r_len < LEN_W'(KEY_CHARS));
        for (int j = 0; j < KEY_CHARS; j++) begin
            n_chars[j] = (add_ok && (r_len == LEN_W'(j))) ? folded : r_chars[j];
            n_token[8*j +: 8] = n_chars[j];
        end
        n_len  = add_ok ? r_len + LEN_W'(1) : r_len;
        n_long = r_long || (kept && !add_ok);
        finish = space || i_end_of_chunk;
        emit   = finish && ((n_len != '0) || n_long);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_long  <= 1'b0;
            r_valid <= 1'b0;
            for (int j = 0; j < KEY_CHARS; j++) begin
                r_chars[j] <= '0;
            end
        end else begin
            if (accept) begin
                if (finish) begin
                    r_len  <= '0;
                    r_long <= 1'b0;
                    for (int j = 0; j < KEY_CHARS; j++) begin
                        r_chars[j] <= '0;
                    end
                end else begin
                    r_len   <= n_len;
                    r_long  <= n_long;
                    r_chars <= n_chars;
                end
            end
            if (accept && emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_token        <= n_token;
            r_tag.too_long <= n_long;
            r_tag.matched  <= 1'b0;
            r_tag.index    <= '0;
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

[rtl/core/kwc_cell.sv]
// one keyword cell: holds a keyword slot and its count, compares the token
// passing through and hands it to the next cell; depends on kwc_pkg
`default_nettype none

module kwc_cell #(
    parameter int KEY_CHARS   = kwc_pkg::KWC_KEY_CHARS,
    parameter int COUNT_WIDTH = kwc_pkg::KWC_COUNT_WIDTH,
    parameter int CELL_IDX    = 0
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [kwc_pkg::KWC_SLOT_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output      logic                           o_ready,
    input  wire logic [8*KEY_CHARS-1:0]         i_token,
    input  wire kwc_pkg::t_tag                  i_tag,
    input  wire logic [COUNT_WIDTH-1:0]         i_count,
    output      logic                           o_valid,
    input  wire logic                           i_ready,
    output      logic [8*KEY_CHARS-1:0]         o_token,
    output      kwc_pkg::t_tag                  o_tag,
    output      logic [COUNT_WIDTH-1:0]         o_count
);

    logic [kwc_pkg::KWC_SLOT_W-1:0] r_slot;
    logic [COUNT_WIDTH-1:0]         r_keep, n_keep;
    logic                           r_valid;
    logic [8*KEY_CHARS-1:0]         r_token;
    kwc_pkg::t_tag                  r_tag;
    logic [COUNT_WIDTH-1:0]         r_count;
    logic                           accept, hit;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        hit    = !i_tag.matched && !i_tag.too_long && (r_slot != '0) &&
                 (r_slot == kwc_pkg::KWC_SLOT_W'(i_token));
        // saturating increment
        n_keep = (r_keep == '1) ? r_keep : r_keep + COUNT_WIDTH'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_keep  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slot <= i_cfg_data;
            end
            if (accept && hit) begin
                r_keep <= n_keep;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_token <= i_token;
            if (hit) begin
                r_tag.too_long <= i_tag.too_long;
                r_tag.matched  <= 1'b1;
                r_tag.index    <= kwc_pkg::KWC_IDX_W'(CELL_IDX);
                r_count        <= n_keep;
            end else begin
                r_tag   <= i_tag;
                r_count <= i_count;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;
    assign o_tag   = r_tag;
    assign o_count = r_count;

endmodule

`default_nettype wire

[rtl/core/keyword_token_match_counter_core.sv]
// Keyword token match counter, top level.
// Text enters on i_in, one byte per beat; end_of_chunk marks the last byte
// of a chunk and closes any open token. Whitespace bytes close tokens too.
// Each token with at least one kept character gives one beat on o_out:
// matched, the first equal keyword slot and that slot's count after the
// increment (both zero when nothing matched). Tokens longer than KEY_CHARS
// kept characters give a beat with matched low.
// Keywords are written on i_cfg_we / i_cfg_index / i_cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// Writes to indexes at or above NUM_KEYWORDS are dropped. Throughput: one
// byte per cycle while the receiver is not stalled. From the byte that ends
// a token, its result passes the tokenizer register, then each keyword cell.
// A stalled receiver holds the result in the last cell; the row keeps
// filling its empty stages and input ready drops only once the tokenizer
// register and every cell ahead of it are full.
// Reset (synchronous, active low) clears the open token, all keyword slots,
// all counts and every stage valid.
`default_nettype none

module keyword_token_match_counter_core #(
    parameter int NUM_KEYWORDS = kwc_pkg::KWC_NUM_KEYWORDS,
    parameter int KEY_CHARS    = kwc_pkg::KWC_KEY_CHARS,
    parameter int COUNT_WIDTH  = kwc_pkg::KWC_COUNT_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    kwc_in_if.sink                                 i_in,
    kwc_out_if.source                              o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [kwc_pkg::KWC_REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [kwc_pkg::KWC_SLOT_W-1:0]    i_cfg_data
);

    logic                   stg_valid [NUM_KEYWORDS+1];
    logic                   stg_ready [NUM_KEYWORDS+1];
    logic [8*KEY_CHARS-1:0] stg_token [NUM_KEYWORDS+1];
    kwc_pkg::t_tag          stg_tag   [NUM_KEYWORDS+1];
    logic [COUNT_WIDTH-1:0] stg_count [NUM_KEYWORDS+1];

    kwc_tokenizer #(
        .KEY_CHARS(KEY_CHARS)
    ) u_tokenizer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_text_byte   (i_in.text_byte),
        .i_end_of_chunk(i_in.end_of_chunk),
        .o_valid       (stg_valid[0]),
        .i_ready       (stg_ready[0]),
        .o_token       (stg_token[0]),
        .o_tag         (stg_tag[0])
    );

    assign stg_count[0] = '0;

    for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_cell
        kwc_cell #(
            .KEY_CHARS  (KEY_CHARS),
            .COUNT_WIDTH(COUNT_WIDTH),
            .CELL_IDX   (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cfg_we  (i_cfg_we &&
                        (i_cfg_index == kwc_pkg::KWC_REG_IDX_W'(k))),
            .i_cfg_data(i_cfg_data),
            .i_valid   (stg_valid[k]),
            .o_ready   (stg_ready[k]),
            .i_token   (stg_token[k]),
            .i_tag     (stg_tag[k]),
            .i_count   (stg_count[k]),
            .o_valid   (stg_valid[k+1]),
            .i_ready   (stg_ready[k+1]),
            .o_token   (stg_token[k+1]),
            .o_tag     (stg_tag[k+1]),
            .o_count   (stg_count[k+1])
        );
    end

    assign o_out.valid         = stg_valid[NUM_KEYWORDS];
    assign stg_ready[NUM_KEYWORDS] = o_out.ready;
    assign o_out.matched       = stg_tag[NUM_KEYWORDS].matched;
    assign o_out.keyword_index = stg_tag[NUM_KEYWORDS].index;
    assign o_out.match_count   = kwc_pkg::KWC_MATCH_W'(stg_count[NUM_KEYWORDS]);

    // an empty token can never reach a keyword, slots are never zero on a hit
    a_match_token_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.matched) |-> (stg_token[NUM_KEYWORDS] != '0))
        else $error("matched result carries an empty token");

    a_match_not_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.matched) |-> !stg_tag[NUM_KEYWORDS].too_long)
        else $error("overlong token reported as matched");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.matched) |->
            ((o_out.keyword_index == '0) && (stg_count[NUM_KEYWORDS] == '0)))
        else $error("unmatched result has nonzero index or count");

    a_match_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.matched) |->
            ((stg_count[NUM_KEYWORDS] != '0) &&
             (int'(o_out.keyword_index) < NUM_KEYWORDS)))
        else $error("matched result has zero count or bad index");

endmodule

`default_nettype wire
